// ----- rtl/core/usbctl_pkg.sv -----
package usbctl_pkg;

	// Event codes carried in the cmd field
	typedef enum logic [1:0] {
		CMD_COMPLETE  = 2'd0,
		CMD_NOT_READY = 2'd1,
		CMD_REPLY     = 2'd2,
		CMD_START     = 2'd3
	} cmd_t;

	// Action codes carried in the action field
	typedef enum logic [2:0] {
		ACT_CONFIGURE   = 3'd0,
		ACT_START_XFER  = 3'd1,
		ACT_CLEAR_RING  = 3'd2,
		ACT_END_XFER    = 3'd3,
		ACT_STALL       = 3'd4,
		ACT_SET_ADDRESS = 3'd5,
		ACT_RESET_CONF  = 3'd6,
		ACT_FORWARD     = 3'd7
	} act_t;

	// Transfer kinds for start transfer
	typedef enum logic [1:0] {
		KIND_SETUP       = 2'd0,
		KIND_DATA        = 2'd1,
		KIND_STATUS_TWO  = 2'd2,
		KIND_STATUS_THREE = 2'd3
	} kind_t;

	// Control transfer phases
	typedef enum logic [2:0] {
		PH_SETUP    = 3'd0,
		PH_DATA_OUT = 3'd1,
		PH_DATA_IN  = 3'd2,
		PH_WAIT_OUT = 3'd3,
		PH_WAIT_IN  = 3'd4,
		PH_STATUS   = 3'd5
	} phase_t;

	// Not-ready stage codes
	localparam logic [1:0] STAGE_DATA   = 2'd1;
	localparam logic [1:0] STAGE_STATUS = 2'd2;

	// Endpoint codes
	localparam logic EP_OUT = 1'b0;
	localparam logic EP_IN  = 1'b1;

	// Standard requests handled locally
	localparam logic [7:0] REQ_TYPE_STD_OUT = 8'd0;
	localparam logic [7:0] REQ_SET_ADDRESS  = 8'd5;
	localparam logic [7:0] REQ_SET_CONFIG   = 8'd9;

	localparam logic [15:0] SETUP_BYTES     = 16'd8;
	localparam logic [15:0] BUF_SIZE_RESET  = 16'd4096;
	localparam logic [2:0]  MAX_ACTIONS     = 3'd4;

	// Configuration register indexes
	localparam logic CFG_BUFFER_SIZE = 1'b0;
	localparam logic CFG_UPPER_BOUND = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        ep_num;
		logic [1:0]  stage;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_length;
		logic [15:0] bytes_remaining;
		logic        reply_ok;
		logic [15:0] reply_length;
	} evt_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic        endpoint;
		logic [1:0]  transfer_kind;
		logic [15:0] byte_count;
		logic [15:0] device_address;
		logic        forward_is_out;
		logic        out_stalled;
		logic        last;
	} act_item_t;

	typedef struct packed {
		logic [15:0] buffer_size;
		logic        upper_layer_bound;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  req_type;
		logic [7:0]  req_code;
		logic [15:0] req_value;
		logic [15:0] req_length;
		logic        awaiting;
		logic [15:0] reply_limit;
		logic        stall;
	} ctx_t;

	typedef struct packed {
		act_item_t [3:0] item;
		logic [2:0]      cnt;
	} bundle_t;

	function automatic act_item_t mk_item(act_t a, logic ep, kind_t kind,
			logic [15:0] cnt, logic [15:0] addr, logic fwd, logic stall);
		act_item_t r;
		r.action         = a;
		r.endpoint       = ep;
		r.transfer_kind  = kind;
		r.byte_count     = cnt;
		r.device_address = addr;
		r.forward_is_out = fwd;
		r.out_stalled    = stall;
		r.last           = 1'b0;
		return r;
	endfunction

	// Append one action to a bundle; drop it if the bundle is full
	function automatic bundle_t push(bundle_t b, act_item_t r);
		bundle_t o;
		o = b;
		if (b.cnt < MAX_ACTIONS) begin
			o.item[b.cnt[1:0]] = r;
			o.cnt = b.cnt + 3'd1;
		end
		return o;
	endfunction

endpackage

// ----- rtl/core/usbctl_decode.sv -----
module usbctl_decode import usbctl_pkg::*; (
	input  evt_item_t evt,
	input  ctx_t      ctx,
	input  cfg_t      cfg,
	output ctx_t      ctx_next,
	output bundle_t   bundle
);

	logic        do_req;
	logic [15:0] req_len;
	logic [15:0] fwd_len;
	logic        is_out;
	logic        three;
	logic        tail_clear;
	logic        tail_end;
	logic        tail_end_ep;
	logic        tail_stall;
	logic        tail_setup;
	kind_t       status_kind;
	ctx_t        n;
	bundle_t     b;

	always_comb begin
		n           = ctx;
		b           = '0;
		do_req      = 1'b0;
		req_len     = '0;
		fwd_len     = '0;
		is_out      = 1'b0;
		three       = 1'b0;
		tail_clear  = 1'b0;
		tail_end    = 1'b0;
		tail_end_ep = EP_OUT;
		tail_stall  = 1'b0;
		tail_setup  = 1'b0;
		status_kind = (ctx.req_length != 16'd0) ? KIND_STATUS_THREE : KIND_STATUS_TWO;

		// Event dispatch
		case (evt.cmd)
			CMD_COMPLETE: begin
				unique case (ctx.phase)
					PH_SETUP: begin
						n.stall      = 1'b0;
						n.req_type   = evt.request_type;
						n.req_code   = evt.request_code;
						n.req_value  = evt.request_value;
						n.req_length = evt.request_length;
						three  = evt.request_length != 16'd0;
						is_out = !evt.request_type[7];
						if (three && is_out) begin
							b = push(b, mk_item(ACT_START_XFER, EP_OUT, KIND_DATA,
								cfg.buffer_size, '0, 1'b0, n.stall));
							n.phase = PH_DATA_OUT;
						end else begin
							n.phase = three ? PH_DATA_IN : PH_WAIT_IN;
							do_req  = 1'b1;
							req_len = three ? cfg.buffer_size : 16'd0;
						end
					end
					PH_DATA_OUT: begin
						// Overrun of the buffer saturates the received length at zero
						n.phase = PH_WAIT_IN;
						do_req  = 1'b1;
						req_len = (evt.bytes_remaining > cfg.buffer_size) ? 16'd0
							: cfg.buffer_size - evt.bytes_remaining;
					end
					PH_DATA_IN: n.phase = PH_WAIT_OUT;
					PH_STATUS:  tail_setup = 1'b1;
					default: ;
				endcase
			end
			CMD_NOT_READY: begin
				unique case (ctx.phase)
					PH_SETUP: begin
						if (evt.stage == STAGE_DATA || evt.stage == STAGE_STATUS) begin
							tail_clear = 1'b1;
							tail_stall = 1'b1;
							tail_setup = 1'b1;
						end
					end
					PH_DATA_OUT: begin
						if (evt.ep_num == EP_IN && evt.stage == STAGE_DATA) begin
							tail_clear  = 1'b1;
							tail_end    = 1'b1;
							tail_end_ep = EP_OUT;
							tail_stall  = 1'b1;
							tail_setup  = 1'b1;
						end
					end
					PH_DATA_IN: begin
						if (evt.ep_num == EP_OUT && evt.stage == STAGE_DATA) begin
							tail_clear  = 1'b1;
							tail_end    = 1'b1;
							tail_end_ep = EP_IN;
							tail_stall  = 1'b1;
							tail_setup  = 1'b1;
						end
					end
					PH_WAIT_OUT: begin
						if (evt.ep_num == EP_OUT) begin
							b = push(b, mk_item(ACT_START_XFER, EP_OUT, status_kind,
								'0, '0, 1'b0, n.stall));
							n.phase = PH_STATUS;
						end
					end
					PH_WAIT_IN: begin
						if (evt.ep_num == EP_IN) begin
							b = push(b, mk_item(ACT_START_XFER, EP_IN, status_kind,
								'0, '0, 1'b0, n.stall));
							n.phase = PH_STATUS;
						end
					end
					default: ;
				endcase
			end
			CMD_REPLY: begin
				// Ignore a reply nobody waits for
				if (ctx.awaiting) begin
					n.awaiting = 1'b0;
					if (!evt.reply_ok) begin
						tail_clear = 1'b1;
						tail_stall = 1'b1;
						tail_setup = 1'b1;
					end else if (ctx.req_type[7]) begin
						if (evt.reply_length > ctx.reply_limit) begin
							tail_clear = 1'b1;
							tail_stall = 1'b1;
							tail_setup = 1'b1;
						end else begin
							b = push(b, mk_item(ACT_START_XFER, EP_IN, KIND_DATA,
								evt.reply_length, '0, 1'b0, n.stall));
						end
					end
				end
			end
			default: begin
				b = push(b, mk_item(ACT_CONFIGURE, EP_OUT, KIND_SETUP, '0, '0, 1'b0, n.stall));
				b = push(b, mk_item(ACT_CONFIGURE, EP_IN, KIND_SETUP, '0, '0, 1'b0, n.stall));
				tail_setup = 1'b1;
			end
		endcase

		// Handle the saved request: set address locally, otherwise forward it, or stall if no upper layer is bound
		if (do_req) begin
			fwd_len = req_len;
			if (n.req_type == REQ_TYPE_STD_OUT && n.req_code == REQ_SET_ADDRESS) begin
				b = push(b, mk_item(ACT_SET_ADDRESS, EP_OUT, KIND_SETUP, '0,
					n.req_value, 1'b0, n.stall));
			end else begin
				if (n.req_type == REQ_TYPE_STD_OUT && n.req_code == REQ_SET_CONFIG) begin
					b = push(b, mk_item(ACT_RESET_CONF, EP_OUT, KIND_SETUP, '0, '0,
						1'b0, n.stall));
					fwd_len = '0;
				end
				if (!cfg.upper_layer_bound) begin
					tail_clear = 1'b1;
					tail_stall = 1'b1;
					tail_setup = 1'b1;
				end else begin
					b = push(b, mk_item(ACT_FORWARD, EP_OUT, KIND_SETUP,
						n.req_type[7] ? 16'd0 : fwd_len, '0, !n.req_type[7], n.stall));
					n.awaiting    = 1'b1;
					n.reply_limit = fwd_len;
				end
			end
		end

		// Abort tail: clear ring, end transfer, stall, then queue a setup
		if (tail_clear)
			b = push(b, mk_item(ACT_CLEAR_RING, EP_OUT, KIND_SETUP, '0, '0, 1'b0, n.stall));
		if (tail_end)
			b = push(b, mk_item(ACT_END_XFER, tail_end_ep, KIND_SETUP, '0, '0, 1'b0, n.stall));
		if (tail_stall) begin
			n.stall = 1'b1;
			b = push(b, mk_item(ACT_STALL, EP_OUT, KIND_SETUP, '0, '0, 1'b0, n.stall));
		end
		if (tail_setup) begin
			b = push(b, mk_item(ACT_START_XFER, EP_OUT, KIND_SETUP, SETUP_BYTES, '0,
				1'b0, n.stall));
			n.phase    = PH_SETUP;
			n.awaiting = 1'b0;
		end

		// Mark the final action of the event
		if (b.cnt != 3'd0)
			b.item[2'(b.cnt - 3'd1)].last = 1'b1;

		ctx_next = n;
		bundle   = b;
	end

endmodule

// ----- rtl/core/usbctl_emit.sv -----
module usbctl_emit import usbctl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load_valid,
	output logic      load_ready,
	input  bundle_t   load_bundle,
	output logic      act_valid,
	input  logic      act_ready,
	output act_item_t act
);

	act_item_t [3:0] item_q;
	logic [2:0]      rem_q;
	logic [1:0]      idx_q;

	assign act_valid  = rem_q != 3'd0;
	assign act        = item_q[idx_q];
	// Take a new bundle once the last pending action leaves
	assign load_ready = (rem_q == 3'd0) || (rem_q == 3'd1 && act_ready);

	// Hold the bundle and step through its actions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load_valid && load_ready) begin
			rem_q <= load_bundle.cnt;
			idx_q <= '0;
		end else if (act_valid && act_ready) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready)
			item_q <= load_bundle.item;
	end

endmodule

// ----- rtl/core/usb_control_endpoint_sequencer.sv -----
// Endpoint-0 control transfer sequencer.
// Event channel (evt_valid/evt_ready/evt): one transaction per endpoint event
// (transfer complete, transfer not ready, upper-layer reply, start).
// Action channel (act_valid/act_ready/act): zero to four actions per event,
// one transaction each, in order; the final action of an event has last set.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; index 0 is the buffer size, index 1 the upper-layer-bound flag.
// Write it only while no event is in flight.
// An accepted event waits in the input register and is decoded combinationally;
// when the action register takes its bundle the context advances and the first
// action becomes valid. Events that produce no action only update the context.
// Throughput: the action register emits one action per cycle while act_ready
// is high; the input register holds one further event while earlier actions
// drain.
// Reset clears the phase to setup, the saved request, the pending-reply flag
// and the stall mark; buffer size returns to 4096 and the upper layer is
// taken as bound. A stalled receiver holds the current action; the event
// input backs up after one buffered event.
module usb_control_endpoint_sequencer import usbctl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	output logic        evt_ready,
	input  evt_item_t   evt,
	output logic        act_valid,
	input  logic        act_ready,
	output act_item_t   act,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	evt_item_t evt_s1;
	logic      valid_s1;
	ctx_t      ctx_q;
	ctx_t      ctx_next;
	cfg_t      cfg_q;
	bundle_t   bundle;
	logic      load_ready;
	logic      advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && load_ready;
	assign evt_ready = !valid_s1 || load_ready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_size       <= BUF_SIZE_RESET;
			cfg_q.upper_layer_bound <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BUFFER_SIZE: cfg_q.buffer_size       <= cfg_data;
				CFG_UPPER_BOUND: cfg_q.upper_layer_bound <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (evt_valid && evt_ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready)
			evt_s1 <= evt;
	end

	// Advance the transfer context as each event is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.phase       <= PH_SETUP;
			ctx_q.req_type    <= '0;
			ctx_q.req_code    <= '0;
			ctx_q.req_value   <= '0;
			ctx_q.req_length  <= '0;
			ctx_q.awaiting    <= 1'b0;
			ctx_q.reply_limit <= '0;
			ctx_q.stall       <= 1'b0;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	usbctl_decode u_decode (
		.evt      (evt_s1),
		.ctx      (ctx_q),
		.cfg      (cfg_q),
		.ctx_next (ctx_next),
		.bundle   (bundle)
	);

	usbctl_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (valid_s1),
		.load_ready  (load_ready),
		.load_bundle (bundle),
		.act_valid   (act_valid),
		.act_ready   (act_ready),
		.act         (act)
	);

endmodule

// ----- tb/usbctl_action_checker.sv -----
module usbctl_action_checker import usbctl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	input  logic        evt_ready,
	input  evt_item_t   evt,
	input  logic        act_valid,
	input  logic        act_ready,
	input  act_item_t   act,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          expected_left
);

	localparam int REPORT_LIMIT = 10;

	// Shadow copies of the configuration registers
	logic [15:0] buf_bytes;
	logic        upper_bound;

	// Control transfer state
	phase_t      phase;
	logic [7:0]  req_type;
	logic [7:0]  req_code;
	logic [15:0] req_value;
	logic [15:0] req_length;
	logic        reply_pending;
	logic [15:0] reply_cap;
	logic        out_stall;

	// Actions of the event being predicted, and all actions still owed by the block
	act_item_t   event_actions[$];
	act_item_t   expected_actions[$];

	function automatic string describe(input act_item_t a);
		return $sformatf("act=%0d ep=%0d kind=%0d cnt=%0d addr=%0d fwd=%0d stall=%0d last=%0d",
			a.action, a.endpoint, a.transfer_kind, a.byte_count, a.device_address,
			a.forward_is_out, a.out_stalled, a.last);
	endfunction

	// Append one action, tagged with the current stall mark; drop past four
	task automatic add_action(input act_t code, input logic ep, input kind_t kind,
			input logic [15:0] count, input logic [15:0] addr, input logic fwd);
		act_item_t r;
		r.action         = code;
		r.endpoint       = ep;
		r.transfer_kind  = kind;
		r.byte_count     = count;
		r.device_address = addr;
		r.forward_is_out = fwd;
		r.out_stalled    = out_stall;
		r.last           = 1'b0;
		if (event_actions.size() < MAX_ACTIONS)
			event_actions.push_back(r);
	endtask

	task automatic queue_setup();
		add_action(ACT_START_XFER, EP_OUT, KIND_SETUP, SETUP_BYTES, 16'd0, 1'b0);
		phase         = PH_SETUP;
		reply_pending = 1'b0;
	endtask

	// Stall endpoint-0 out and restart with a fresh setup
	task automatic stall_and_restart();
		add_action(ACT_CLEAR_RING, EP_OUT, KIND_SETUP, 16'd0, 16'd0, 1'b0);
		out_stall = 1'b1;
		add_action(ACT_STALL, EP_OUT, KIND_SETUP, 16'd0, 16'd0, 1'b0);
		queue_setup();
	endtask

	// Handle set address locally, otherwise forward to the upper layer, or stall if it is not bound
	task automatic route_request(input logic [15:0] len);
		logic        is_out;
		logic [15:0] n;
		n = len;
		if (req_type == REQ_TYPE_STD_OUT && req_code == REQ_SET_ADDRESS) begin
			add_action(ACT_SET_ADDRESS, EP_OUT, KIND_SETUP, 16'd0, req_value, 1'b0);
			return;
		end
		if (req_type == REQ_TYPE_STD_OUT && req_code == REQ_SET_CONFIG) begin
			add_action(ACT_RESET_CONF, EP_OUT, KIND_SETUP, 16'd0, 16'd0, 1'b0);
			n = 16'd0;
		end
		if (!upper_bound) begin
			stall_and_restart();
			return;
		end
		is_out = !req_type[7];
		add_action(ACT_FORWARD, EP_OUT, KIND_SETUP, is_out ? n : 16'd0, 16'd0, is_out);
		reply_pending = 1'b1;
		reply_cap     = n;
	endtask

	task automatic on_transfer_complete(input evt_item_t e);
		logic [15:0] got;
		case (phase)
		PH_SETUP: begin
			out_stall  = 1'b0;
			req_type   = e.request_type;
			req_code   = e.request_code;
			req_value  = e.request_value;
			req_length = e.request_length;
			if (req_length != 16'd0 && !req_type[7]) begin
				add_action(ACT_START_XFER, EP_OUT, KIND_DATA, buf_bytes, 16'd0, 1'b0);
				phase = PH_DATA_OUT;
			end else if (req_length != 16'd0) begin
				phase = PH_DATA_IN;
				route_request(buf_bytes);
			end else begin
				phase = PH_WAIT_IN;
				route_request(16'd0);
			end
		end
		PH_DATA_OUT: begin
			// saturate the received length on overrun
			got   = (e.bytes_remaining > buf_bytes) ? 16'd0 : buf_bytes - e.bytes_remaining;
			phase = PH_WAIT_IN;
			route_request(got);
		end
		PH_DATA_IN: phase = PH_WAIT_OUT;
		PH_STATUS: queue_setup();
		default: ;
		endcase
	endtask

	task automatic on_not_ready(input logic ep, input logic [1:0] stg);
		kind_t status_kind;
		if (req_length != 16'd0)
			status_kind = KIND_STATUS_THREE;
		else
			status_kind = KIND_STATUS_TWO;
		case (phase)
		PH_SETUP: begin
			if (stg == STAGE_DATA || stg == STAGE_STATUS)
				stall_and_restart();
		end
		PH_DATA_OUT, PH_DATA_IN: begin
			// wrong-direction data request: end the transfer and stall
			if (stg == STAGE_DATA && ep == (phase == PH_DATA_OUT ? EP_IN : EP_OUT)) begin
				add_action(ACT_CLEAR_RING, EP_OUT, KIND_SETUP, 16'd0, 16'd0, 1'b0);
				add_action(ACT_END_XFER, phase == PH_DATA_OUT ? EP_OUT : EP_IN,
					KIND_SETUP, 16'd0, 16'd0, 1'b0);
				out_stall = 1'b1;
				add_action(ACT_STALL, EP_OUT, KIND_SETUP, 16'd0, 16'd0, 1'b0);
				queue_setup();
			end
		end
		PH_WAIT_OUT, PH_WAIT_IN: begin
			if (ep == (phase == PH_WAIT_OUT ? EP_OUT : EP_IN)) begin
				add_action(ACT_START_XFER, ep, status_kind, 16'd0, 16'd0, 1'b0);
				phase = PH_STATUS;
			end
		end
		default: ;
		endcase
	endtask

	task automatic on_reply(input logic ok, input logic [15:0] rlen);
		if (!reply_pending)
			return;
		reply_pending = 1'b0;
		if (!ok) begin
			stall_and_restart();
		end else if (req_type[7]) begin
			if (rlen > reply_cap)
				stall_and_restart();
			else
				add_action(ACT_START_XFER, EP_IN, KIND_DATA, rlen, 16'd0, 1'b0);
		end
	endtask

	// Work out the actions of one accepted event and queue them
	task automatic predict_actions(input evt_item_t e);
		event_actions.delete();
		case (e.cmd)
		CMD_COMPLETE: on_transfer_complete(e);
		CMD_NOT_READY: on_not_ready(e.ep_num, e.stage);
		CMD_REPLY: on_reply(e.reply_ok, e.reply_length);
		default: begin
			add_action(ACT_CONFIGURE, EP_OUT, KIND_SETUP, 16'd0, 16'd0, 1'b0);
			add_action(ACT_CONFIGURE, EP_IN, KIND_SETUP, 16'd0, 16'd0, 1'b0);
			queue_setup();
		end
		endcase
		if (event_actions.size() > 0)
			event_actions[event_actions.size() - 1].last = 1'b1;
		foreach (event_actions[i])
			expected_actions.push_back(event_actions[i]);
	endtask

	task automatic check_action(input act_item_t got);
		act_item_t want;
		if (expected_actions.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t unexpected action transaction: %s", $time, describe(got));
			return;
		end
		want = expected_actions.pop_front();
		if (got.action !== want.action || got.endpoint !== want.endpoint ||
				got.transfer_kind !== want.transfer_kind ||
				got.byte_count !== want.byte_count ||
				got.device_address !== want.device_address ||
				got.forward_is_out !== want.forward_is_out ||
				got.out_stalled !== want.out_stalled || got.last !== want.last) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT) begin
				$display("%0t action mismatch, expected %s", $time, describe(want));
				$display("%0t                  actual   %s", $time, describe(got));
			end
		end
	endtask

	// Compare first, then track register writes, then predict the new event
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_bytes     = BUF_SIZE_RESET;
			upper_bound   = 1'b1;
			phase         = PH_SETUP;
			req_type      = 8'd0;
			req_code      = 8'd0;
			req_value     = 16'd0;
			req_length    = 16'd0;
			reply_pending = 1'b0;
			reply_cap     = 16'd0;
			out_stall     = 1'b0;
			expected_actions.delete();
			mismatch_count = 0;
			expected_left  = 0;
		end else begin
			if (act_valid && act_ready)
				check_action(act);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BUFFER_SIZE)
					buf_bytes = cfg_data;
				else
					upper_bound = cfg_data[0];
			end
			if (evt_valid && evt_ready)
				predict_actions(evt);
			expected_left = expected_actions.size();
		end
	end

endmodule

// ----- tb/usb_control_endpoint_sequencer_tb.sv -----
module usb_control_endpoint_sequencer_tb;
	import usbctl_pkg::*;

	localparam int          CYCLE_LIMIT  = 500000;
	localparam int          DRAIN_CYCLES = 8;
	localparam logic [1:0]  STAGE_SETUP  = 2'd0;
	localparam logic [1:0]  STAGE_BAD    = 2'd3;
	localparam logic [7:0]  REQ_DIR_IN   = 8'h80;

	// Receiver stall patterns
	localparam logic [1:0]  RDY_ALWAYS   = 2'd0;
	localparam logic [1:0]  RDY_RANDOM   = 2'd1;
	localparam logic [1:0]  RDY_SPARSE   = 2'd2;
	localparam logic [1:0]  RDY_HOLD     = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        evt_valid;
	logic        evt_ready;
	evt_item_t   evt;
	logic        act_valid;
	logic        act_ready;
	act_item_t   act;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	int          mismatch_count;
	int          expected_left;
	int unsigned cycle_count;
	int unsigned events_sent;
	int unsigned burst_left;
	logic [15:0] buf_bytes;
	logic [1:0]  ready_mode;
	logic [7:0]  ready_span;

	usb_control_endpoint_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.act_valid (act_valid),
		.act_ready (act_ready),
		.act       (act),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	usbctl_action_checker action_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.evt_valid      (evt_valid),
		.evt_ready      (evt_ready),
		.evt            (evt),
		.act_valid      (act_valid),
		.act_ready      (act_ready),
		.act            (act),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.expected_left  (expected_left)
	);

	always #1 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("usb_control_endpoint_sequencer test failed");
			$finish;
		end
	end

	// Stall the action channel on a random pattern, redrawn whenever its span counter runs out
	always @(negedge clk) begin
		if (ready_span == 8'd0) begin
			ready_mode <= 2'($urandom_range(0, 3));
			ready_span <= 8'($urandom_range(4, 40));
		end else begin
			ready_span <= ready_span - 8'd1;
		end
		case (ready_mode)
		RDY_ALWAYS: act_ready <= 1'b1;
		RDY_RANDOM: act_ready <= ($urandom_range(0, 3) != 0);
		RDY_SPARSE: act_ready <= (ready_span[1:0] == 2'd0);
		RDY_HOLD: act_ready <= 1'b0;
		endcase
	end

	// Random event with every field filled; the caller overrides what matters
	function automatic evt_item_t make_event(input cmd_t code);
		evt_item_t e;
		e.cmd             = code;
		e.ep_num          = 1'($urandom_range(0, 1));
		e.stage           = 2'($urandom_range(0, 3));
		e.request_type    = 8'($urandom);
		e.request_code    = 8'($urandom);
		e.request_value   = 16'($urandom);
		e.request_length  = 16'($urandom);
		e.bytes_remaining = 16'($urandom);
		e.reply_ok        = 1'($urandom_range(0, 1));
		e.reply_length    = 16'($urandom);
		return e;
	endfunction

	// Drive one event transaction in bursts separated by random gaps; called at a falling edge
	task automatic send_event(input evt_item_t item);
		if (burst_left == 0) begin
			evt_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(20, 50);
			else
				burst_left = $urandom_range(1, 8);
		end
		evt       <= item;
		evt_valid <= 1'b1;
		do @(posedge clk); while (!evt_ready);
		@(negedge clk);
		burst_left--;
		events_sent++;
	endtask

	task automatic send_start();
		send_event(make_event(CMD_START));
	endtask

	task automatic send_setup(input logic [7:0] rtype, input logic [7:0] rcode,
			input logic [15:0] value, input logic [15:0] len);
		evt_item_t e;
		e = make_event(CMD_COMPLETE);
		e.request_type   = rtype;
		e.request_code   = rcode;
		e.request_value  = value;
		e.request_length = len;
		send_event(e);
	endtask

	task automatic send_complete(input logic [15:0] rem);
		evt_item_t e;
		e = make_event(CMD_COMPLETE);
		e.bytes_remaining = rem;
		send_event(e);
	endtask

	task automatic send_not_ready(input logic ep, input logic [1:0] stg);
		evt_item_t e;
		e = make_event(CMD_NOT_READY);
		e.ep_num = ep;
		e.stage  = stg;
		send_event(e);
	endtask

	task automatic send_reply(input logic ok, input logic [15:0] len);
		evt_item_t e;
		e = make_event(CMD_REPLY);
		e.reply_ok     = ok;
		e.reply_length = len;
		send_event(e);
	endtask

	task automatic send_noise(input int unsigned n);
		repeat (n) send_event(make_event(cmd_t'($urandom_range(0, 3))));
	endtask

	// Hold off the sender until every expected action has drained
	task automatic wait_drained();
		evt_valid <= 1'b0;
		do @(negedge clk); while (expected_left != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// One control transfer, mostly well formed, with random content and the odd stray event
	task automatic run_transfer();
		logic [7:0]  rtype;
		logic [7:0]  rcode;
		logic [15:0] len;
		logic [15:0] limit;
		logic [15:0] rlen;
		logic [15:0] rem;
		rtype = 8'($urandom);
		rcode = 8'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			rtype = REQ_TYPE_STD_OUT;
			rcode = $urandom_range(0, 1) ? REQ_SET_ADDRESS : REQ_SET_CONFIG;
		end
		case ($urandom_range(0, 5))
		0, 1: len = 16'd0;
		2: len = 16'($urandom);
		default: len = 16'($urandom_range(1, 64));
		endcase
		if ($urandom_range(0, 11) == 0)
			send_noise($urandom_range(1, 3));
		send_setup(rtype, rcode, 16'($urandom), len);

		// data out stage, sometimes broken by a wrong-direction request
		if (len != 16'd0 && !rtype[7]) begin
			if ($urandom_range(0, 9) == 0) begin
				send_not_ready(EP_IN, STAGE_DATA);
				return;
			end
			if ($urandom_range(0, 7) == 0)
				rem = 16'($urandom);
			else
				rem = 16'($urandom_range(0, buf_bytes));
			send_complete(rem);
		end

		// upper-layer reply, mostly within the allowed length
		limit = (len != 16'd0) ? buf_bytes : 16'd0;
		case ($urandom_range(0, 5))
		0: rlen = 16'($urandom);
		1: rlen = (limit == 16'hFFFF) ? limit : limit + 16'd1;
		default: rlen = 16'($urandom_range(0, limit));
		endcase
		if ($urandom_range(0, 9) != 0)
			send_reply($urandom_range(0, 9) != 0, rlen);

		// data in stage, then the status stage
		if (len != 16'd0 && rtype[7]) begin
			if ($urandom_range(0, 9) == 0) begin
				send_not_ready(EP_OUT, STAGE_DATA);
				return;
			end
			send_complete(16'($urandom));
			send_not_ready(EP_OUT, $urandom_range(0, 1) ? STAGE_STATUS : STAGE_SETUP);
		end else begin
			send_not_ready(EP_IN, STAGE_STATUS);
		end
		if ($urandom_range(0, 11) == 0)
			send_noise(1);
		send_complete(16'($urandom));
	endtask

	task automatic run_phase(input logic [15:0] bytes, input logic bound,
			input int unsigned count);
		int unsigned stop_at;
		wait_drained();
		write_reg(CFG_BUFFER_SIZE, bytes);
		write_reg(CFG_UPPER_BOUND, {15'd0, bound});
		buf_bytes = bytes;
		stop_at   = events_sent + count;
		while (events_sent < stop_at)
			run_transfer();
		wait_drained();
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		evt_valid   = 1'b0;
		evt         = '0;
		act_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_BUFFER_SIZE;
		cfg_data    = 16'd0;
		cycle_count = 0;
		events_sent = 0;
		burst_left  = 0;
		buf_bytes   = BUF_SIZE_RESET;
		ready_mode  = RDY_ALWAYS;
		ready_span  = 8'd0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed sequence at the reset configuration
		send_start();
		send_setup(REQ_TYPE_STD_OUT, REQ_SET_ADDRESS, 16'hFFFF, 16'd0);
		send_not_ready(EP_OUT, STAGE_STATUS);
		send_not_ready(EP_IN, STAGE_STATUS);
		send_complete(16'd0);
		send_not_ready(EP_OUT, STAGE_BAD);
		send_not_ready(EP_IN, STAGE_DATA);
		send_setup(REQ_TYPE_STD_OUT, REQ_SET_CONFIG, 16'h0001, 16'd0);
		send_reply(1'b1, 16'hFFFF);
		send_not_ready(EP_IN, STAGE_STATUS);
		send_complete(16'hFFFF);
		send_setup(REQ_DIR_IN, 8'h06, 16'h0100, 16'hFFFF);
		send_reply(1'b1, BUF_SIZE_RESET + 16'd1);
		send_setup(8'hFF, 8'hFF, 16'hFFFF, 16'd64);
		send_reply(1'b1, BUF_SIZE_RESET);
		send_reply(1'b1, 16'd0);
		send_complete(16'd0);
		send_not_ready(EP_IN, STAGE_STATUS);
		send_not_ready(EP_OUT, STAGE_SETUP);
		send_complete(16'd0);
		send_setup(8'h7F, 8'h00, 16'h0000, 16'd16);
		send_not_ready(EP_IN, STAGE_DATA);
		send_setup(REQ_TYPE_STD_OUT, REQ_SET_CONFIG, 16'h0002, 16'hFFFF);
		send_complete(16'hFFFF);
		send_reply(1'b0, 16'd0);
		send_setup(REQ_DIR_IN, 8'h00, 16'h0000, 16'd2);
		send_not_ready(EP_OUT, STAGE_DATA);
		send_setup(REQ_DIR_IN, 8'h00, 16'h0000, 16'd0);
		send_complete(16'd0);
		send_reply(1'b1, 16'd1);

		// Random transfers across several register settings
		run_phase(BUF_SIZE_RESET, 1'b1, 90);
		run_phase(16'd8, 1'b1, 90);
		run_phase(16'hFFFF, 1'b0, 60);
		run_phase(16'($urandom_range(8, 1024)), 1'b1, 90);

		if (mismatch_count == 0)
			$display("usb_control_endpoint_sequencer test passed");
		else
			$display("usb_control_endpoint_sequencer test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/usbctl_pkg.sv
rtl/core/usbctl_decode.sv
rtl/core/usbctl_emit.sv
rtl/core/usb_control_endpoint_sequencer.sv
tb/usbctl_action_checker.sv
tb/usb_control_endpoint_sequencer_tb.sv
